FILE: rtl/sirle_pkg.sv
// ----------------------------------------------------------------------------
// SGI RLE row decoder package
// Shared types, register indexes and defaults for the row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sirle_pkg;

    // Defaults for the top-level parameters.
    localparam int OUT_LANES_DEF      = 4;
    localparam int MAX_WIDTH_BITS_DEF = 16;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int NUM_LANE_F  = 4;
    localparam int BCOUNT_W    = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    // Header byte fields.
    localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h7F;
    localparam logic [BYTE_W-1:0] LITERAL_BIT = 8'h80;

    // Register reset values.
    localparam logic                  STORAGE_MODE_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST    = 16'h0100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'b1;

    // Storage modes.
    localparam logic MODE_VERBATIM = 1'b0;
    localparam logic MODE_RLE      = 1'b1;

    // Decoder phase within a row.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUNVAL  = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    // Work handed from the byte decoder to the word packer.
    typedef struct packed {
        logic                load;
        logic                row_end;
        logic                dropped;
        logic [COUNT_W-1:0]  keep;
        logic [BYTE_W-1:0]   value;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/sirle_decode.sv
// ----------------------------------------------------------------------------
// SGI RLE byte decoder
// Tracks the header/literal/run phase and the pixel position, and turns each
// accepted byte into a packing job clipped against the row width.
// ----------------------------------------------------------------------------
`default_nettype none

module sirle_decode #(
    parameter int MAX_WIDTH_BITS = sirle_pkg::MAX_WIDTH_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              accept,
    input  wire [sirle_pkg::BYTE_W-1:0]      code_byte,
    input  wire                              row_begin,
    input  wire                              storage_mode,
    input  wire [MAX_WIDTH_BITS-1:0]         row_width,
    output sirle_pkg::job_t                  job
);

    sirle_pkg::phase_t                  phase_reg, phase_next;
    logic [sirle_pkg::COUNT_W-1:0]      remain_reg, remain_next;
    logic [MAX_WIDTH_BITS-1:0]          pos_reg, pos_next;

    sirle_pkg::phase_t                  phase_cur;
    logic [sirle_pkg::COUNT_W-1:0]      remain_cur;
    logic [MAX_WIDTH_BITS-1:0]          pos_cur;
    logic [sirle_pkg::COUNT_W-1:0]      hdr_count;
    logic [sirle_pkg::COUNT_W-1:0]      n_pix;
    logic                               emit;
    logic [MAX_WIDTH_BITS-1:0]          avail;
    logic [MAX_WIDTH_BITS-1:0]          n_ext;
    logic [sirle_pkg::COUNT_W-1:0]      keep;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sirle_pkg::PH_HEADER;
            remain_reg <= '0;
            pos_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
        end
    end

    // A row start clears the state before the byte is looked at.
    assign phase_cur  = row_begin ? sirle_pkg::PH_HEADER : phase_reg;
    assign remain_cur = row_begin ? '0 : remain_reg;
    assign pos_cur    = row_begin ? '0 : pos_reg;
    assign hdr_count  = code_byte[sirle_pkg::COUNT_W-1:0];

    // Clip the pixel count against the room left in the row.
    assign avail = (row_width > pos_cur) ? (row_width - pos_cur) : '0;
    assign n_ext = MAX_WIDTH_BITS'(n_pix);
    assign keep  = (n_ext < avail) ? n_pix : avail[sirle_pkg::COUNT_W-1:0];

    // Phase sequencing and job generation.
    always_comb begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        pos_next     = pos_reg;
        n_pix        = '0;
        emit         = 1'b0;
        job          = '0;
        job.value    = code_byte;
        if (accept) begin
            phase_next  = phase_cur;
            remain_next = remain_cur;
            pos_next    = pos_cur;
            if (storage_mode == sirle_pkg::MODE_VERBATIM) begin
                n_pix = sirle_pkg::COUNT_W'(1);
                emit  = 1'b1;
            end else begin
                case (phase_cur)
                    sirle_pkg::PH_HEADER: begin
                        if (hdr_count == '0) begin
                            phase_next  = sirle_pkg::PH_DONE;
                            remain_next = '0;
                            job.load    = 1'b1;
                            job.row_end = 1'b1;
                        end else begin
                            remain_next = hdr_count;
                            phase_next  = ((code_byte & sirle_pkg::LITERAL_BIT) != '0)
                                        ? sirle_pkg::PH_LITERAL : sirle_pkg::PH_RUNVAL;
                        end
                    end
                    sirle_pkg::PH_LITERAL: begin
                        remain_next = remain_cur - sirle_pkg::COUNT_W'(1);
                        if (remain_next == '0) begin
                            phase_next = sirle_pkg::PH_HEADER;
                        end
                        n_pix = sirle_pkg::COUNT_W'(1);
                        emit  = 1'b1;
                    end
                    sirle_pkg::PH_RUNVAL: begin
                        remain_next = '0;
                        phase_next  = sirle_pkg::PH_HEADER;
                        n_pix       = remain_cur;
                        emit        = 1'b1;
                    end
                    default: begin
                        // Bytes after the row end are ignored.
                    end
                endcase
            end
            if (emit) begin
                pos_next    = pos_cur + MAX_WIDTH_BITS'(keep);
                job.keep    = keep;
                job.dropped = (n_ext > avail);
                job.load    = (keep != '0) || (n_ext > avail);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sirle_pack.sv
// ----------------------------------------------------------------------------
// SGI RLE word packer
// Splits one job into result words of up to LANES pixels, one word a cycle unless the
// output stalls, with a single shared down counter; words wait in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sirle_pack #(
    parameter int OUT_LANES = sirle_pkg::OUT_LANES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire sirle_pkg::job_t               job,
    output logic                               busy,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [sirle_pkg::M_TDATA_W-1:0]    m_tdata,   // lane0..lane3, byte_count, pad
    output logic [sirle_pkg::M_TUSER_W-1:0]    m_tuser,   // row_done, overrun
    output logic                               m_tlast
);

    localparam int Lanes = (OUT_LANES > sirle_pkg::NUM_LANE_F) ? sirle_pkg::NUM_LANE_F
                         : ((OUT_LANES < 1) ? 1 : OUT_LANES);

    logic                               active_reg, active_next;
    logic                               row_end_reg, row_end_next;
    logic                               drop_reg, drop_next;
    logic [sirle_pkg::COUNT_W-1:0]      left_reg, left_next;
    logic [sirle_pkg::BYTE_W-1:0]       value_reg, value_next;

    logic                               ovalid_reg, ovalid_next;
    logic [sirle_pkg::M_TDATA_W-1:0]    odata_reg, odata_next;
    logic [sirle_pkg::M_TUSER_W-1:0]    ouser_reg, ouser_next;
    logic                               olast_reg, olast_next;

    logic                               slot_free;
    logic [sirle_pkg::BCOUNT_W-1:0]     cnt;
    logic [sirle_pkg::COUNT_W-1:0]      left_sub;

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
        row_end_reg <= row_end_next;
        drop_reg    <= drop_next;
        left_reg    <= left_next;
        value_reg   <= value_next;
        odata_reg   <= odata_next;
        ouser_reg   <= ouser_next;
        olast_reg   <= olast_next;
    end

    assign slot_free = !ovalid_reg || m_tready;
    assign cnt       = (left_reg < sirle_pkg::COUNT_W'(Lanes)) ? left_reg[sirle_pkg::BCOUNT_W-1:0]
                                                                : sirle_pkg::BCOUNT_W'(Lanes);
    assign left_sub  = left_reg - sirle_pkg::COUNT_W'(cnt);

    // Word generation: one word per cycle while a job is active and the output register is free.
    always_comb begin
        active_next  = active_reg;
        row_end_next = row_end_reg;
        drop_next    = drop_reg;
        left_next    = left_reg;
        value_next   = value_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        ouser_next   = ouser_reg;
        olast_next   = olast_reg;
        if (job.load) begin
            active_next  = 1'b1;
            row_end_next = job.row_end;
            drop_next    = job.dropped;
            left_next    = job.keep;
            value_next   = job.value;
        end else if (active_reg && slot_free) begin
            ovalid_next = 1'b1;
            odata_next  = '0;
            ouser_next  = '0;
            if (row_end_reg) begin
                ouser_next[0] = 1'b1;
                olast_next    = 1'b1;
                active_next   = 1'b0;
            end else begin
                for (int k = 0; k < sirle_pkg::NUM_LANE_F; k++) begin
                    if (sirle_pkg::BCOUNT_W'(k) < cnt) begin
                        odata_next[k*sirle_pkg::BYTE_W +: sirle_pkg::BYTE_W] = value_reg;
                    end
                end
                odata_next[sirle_pkg::NUM_LANE_F*sirle_pkg::BYTE_W +: sirle_pkg::BCOUNT_W] = cnt;
                left_next     = left_sub;
                olast_next    = (left_sub == '0);
                ouser_next[1] = (left_sub == '0) && drop_reg;
                active_next   = (left_sub != '0);
            end
        end
    end

    assign busy     = active_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: rtl/sgi_image_rle_row_decoder.sv
// ----------------------------------------------------------------------------
// SGI image RLE row decoder
// Decodes one scanline of one channel plane, one stored byte per input beat.
// ----------------------------------------------------------------------------
// The decoder turns every accepted input beat into a job in the same cycle. A
// header with a nonzero count and a byte that arrives after the row end yield
// no word, and the block stays ready. Every other byte loads the word packer,
// which then yields one result word per cycle while the output register can
// take it, and the input stays not ready until the packer has moved its last
// word into the output register. A literal, verbatim, row-end or fully dropped
// byte yields a single word; a run byte yields as many words as its kept pixels
// fill. The final word waits in the output register while the next byte is
// accepted. Output stalls hold the packer and therefore the input.
`default_nettype none

module sgi_image_rle_row_decoder #(
    parameter int OUT_LANES      = sirle_pkg::OUT_LANES_DEF,
    parameter int MAX_WIDTH_BITS = sirle_pkg::MAX_WIDTH_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Configuration write channel.
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [sirle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [sirle_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Stored byte stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [sirle_pkg::BYTE_W-1:0]         s_tdata,    // code_byte
    input  wire                                 s_tuser,    // row_begin
    // Decoded pixel words.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [sirle_pkg::M_TDATA_W-1:0]     m_tdata,    // lane0..lane3, byte_count, pad
    output logic [sirle_pkg::M_TUSER_W-1:0]     m_tuser,    // row_done, overrun
    output logic                                m_tlast     // last_of_item
);

    logic                               mode_reg, mode_next;
    logic [sirle_pkg::CFG_DATA_W-1:0]   width_reg, width_next;
    logic                               busy;
    logic                               accept;
    sirle_pkg::job_t                    job;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sirle_pkg::STORAGE_MODE_RST;
            width_reg <= sirle_pkg::ROW_WIDTH_RST;
        end else begin
            mode_reg  <= mode_next;
            width_reg <= width_next;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        width_next = width_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sirle_pkg::CFG_STORAGE_MODE: mode_next  = cfg_data[0];
                sirle_pkg::CFG_ROW_WIDTH:    width_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;

    sirle_decode #(
        .MAX_WIDTH_BITS (MAX_WIDTH_BITS)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .code_byte    (s_tdata),
        .row_begin    (s_tuser),
        .storage_mode (mode_reg),
        .row_width    (width_reg[MAX_WIDTH_BITS-1:0]),
        .job          (job)
    );

    sirle_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job      (job),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/sirle_checker.sv
// ----------------------------------------------------------------------------
// SGI RLE row decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sirle_checker #(
    parameter int LANES = sirle_pkg::OUT_LANES_DEF
) (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [sirle_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire [sirle_pkg::M_TUSER_W-1:0]     m_tuser,
    input wire                                m_tlast
);

    localparam int BcLo = sirle_pkg::NUM_LANE_F * sirle_pkg::BYTE_W;

    // Lanes actually used by the packer.
    localparam int WordLanes = (LANES > sirle_pkg::NUM_LANE_F) ? sirle_pkg::NUM_LANE_F
                             : ((LANES < 1) ? 1 : LANES);

    // A row-end word carries no pixels and closes its beat group.
    a_row_end_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[BcLo +: sirle_pkg::BCOUNT_W] == '0))
        else $error("row-end word carries pixels or is not last");

    // Overrun is reported only on the final word of a byte.
    a_overrun_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("overrun flagged on a non-final word");

    // Every word before the final one of a byte is full.
    a_full_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[BcLo +: sirle_pkg::BCOUNT_W]
                                  == sirle_pkg::BCOUNT_W'(WordLanes)))
        else $error("partial word before the end of a byte");

    // A stalled beat holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind sgi_image_rle_row_decoder sirle_checker #(
    .LANES (OUT_LANES)
) u_sirle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the SGI image RLE row decoder
// Feeds stored row bytes in verbatim and run-length modes under several row
// widths, with bursty input and a stalling output, and checks every decoded
// pixel word against a cycle-free decoder kept alongside the block.
// ----------------------------------------------------------------------------

module tb;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_AT_BYTE = 60;
    localparam int          SETTLE       = 10;
    localparam logic [7:0]  ROW_END_HDR  = 8'h00;

    // One stored byte as it goes onto the input stream.
    typedef struct {
        logic [sirle_pkg::BYTE_W-1:0] code;
        logic                         row_begin;
    } stored_byte_t;

    // One decoded pixel word as it leaves the block.
    typedef struct packed {
        logic [3:0][7:0]                lanes;
        logic [sirle_pkg::BCOUNT_W-1:0] count;
        logic                           row_done;
        logic                           overrun;
        logic                           last_of_byte;
    } pixel_word_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [sirle_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sirle_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [sirle_pkg::BYTE_W-1:0]     s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [sirle_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [sirle_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                             m_tlast;

    // Stimulus and expectation stores.
    stored_byte_t byte_feed[$];
    pixel_word_t  predicted_words[$];

    // Decoder state and register copies used for prediction.
    logic                             dec_mode  = sirle_pkg::STORAGE_MODE_RST;
    logic [sirle_pkg::CFG_DATA_W-1:0] dec_width = sirle_pkg::ROW_WIDTH_RST;
    sirle_pkg::phase_t                dec_phase = sirle_pkg::PH_HEADER;
    logic [sirle_pkg::COUNT_W-1:0]    dec_left  = '0;
    logic [15:0]                      dec_pos   = '0;

    // Run statistics and bookkeeping.
    int          in_beats     = 0;
    int          out_beats    = 0;
    int          row_ends     = 0;
    int          overrun_words = 0;
    int          mismatches   = 0;
    int          counted      = 0;
    int          stall_cycles = 0;
    int          gap_max      = 0;
    int          burst_left   = 1;
    int          gap_left     = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    logic [15:0] rx_tick      = '0;

    sgi_image_rle_row_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pack n copies of a pixel value into words, dropping what lies past the
    // row width. A byte whose pixels are all dropped still yields one word.
    function automatic void emit_pixels(input logic [7:0] value, input int unsigned n);
        int unsigned avail;
        int unsigned keep;
        int unsigned left;
        int unsigned cnt;
        bit          dropped;
        pixel_word_t w;
        avail   = (dec_width > dec_pos) ? 32'(dec_width - dec_pos) : 0;
        keep    = (n < avail) ? n : avail;
        dropped = (n > keep);
        dec_pos = dec_pos + keep[15:0];
        left    = keep;
        if (keep == 0 && dropped) begin
            w = '0;
            w.overrun = 1'b1;
            w.last_of_byte = 1'b1;
            predicted_words.push_back(w);
        end
        while (left > 0) begin
            cnt = (left < 4) ? left : 4;
            w = '0;
            for (int k = 0; k < cnt; k++)
                w.lanes[k] = value;
            w.count = cnt[sirle_pkg::BCOUNT_W-1:0];
            left -= cnt;
            if (left == 0) begin
                w.overrun = dropped;
                w.last_of_byte = 1'b1;
            end
            predicted_words.push_back(w);
        end
    endfunction

    // Advance the decoder by one stored byte and queue the words it yields.
    function automatic void decode_byte(input logic [7:0] code, input logic row_begin);
        pixel_word_t w;
        int unsigned n;
        if (row_begin) begin
            dec_phase = sirle_pkg::PH_HEADER;
            dec_left  = '0;
            dec_pos   = '0;
        end
        if (dec_mode == sirle_pkg::MODE_VERBATIM) begin
            emit_pixels(code, 1);
            return;
        end
        case (dec_phase)
            sirle_pkg::PH_HEADER: begin
                if ((code & sirle_pkg::COUNT_MASK) == ROW_END_HDR) begin
                    dec_phase = sirle_pkg::PH_DONE;
                    dec_left = '0;
                    w = '0;
                    w.row_done = 1'b1;
                    w.last_of_byte = 1'b1;
                    predicted_words.push_back(w);
                end else begin
                    dec_left = code[sirle_pkg::COUNT_W-1:0];
                    dec_phase = ((code & sirle_pkg::LITERAL_BIT) != 0)
                              ? sirle_pkg::PH_LITERAL : sirle_pkg::PH_RUNVAL;
                end
            end
            sirle_pkg::PH_LITERAL: begin
                dec_left = dec_left - 1'b1;
                if (dec_left == 0)
                    dec_phase = sirle_pkg::PH_HEADER;
                emit_pixels(code, 1);
            end
            sirle_pkg::PH_RUNVAL: begin
                n = 32'(dec_left);
                dec_left = '0;
                dec_phase = sirle_pkg::PH_HEADER;
                emit_pixels(code, n);
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        $display("%0t: word %0d %s expected 0x%0h got 0x%0h",
                 $time, out_beats, field, want, got);
    endtask

    // Input driver: bursts of bytes separated by random gaps.
    always @(posedge aclk) begin : driver
        stored_byte_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
                item = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.code;
                s_tuser  <= item.row_begin;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output receiver: a stall pattern chosen by bits 8:7 of a free-running tick, plus
    // one long hold-off so that the block backs up into its input.
    always @(posedge aclk) begin : receiver
        rx_tick <= rx_tick + 1'b1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && in_beats >= HOLD_AT_BYTE) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            case (rx_tick[8:7])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
                2'd2:    m_tready <= (rx_tick[1:0] != 2'd3);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: register writes and input beats update the prediction, then
    // each output beat is checked against the oldest predicted word.
    always @(posedge aclk) begin : monitor
        pixel_word_t want;
        pixel_word_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sirle_pkg::CFG_STORAGE_MODE)
                    dec_mode = cfg_data[0];
                else if (cfg_index == sirle_pkg::CFG_ROW_WIDTH)
                    dec_width = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
                in_beats <= in_beats + 1;
            end
            if (m_tvalid && m_tready) begin
                got.lanes        = m_tdata[31:0];
                got.count        = m_tdata[34:32];
                got.row_done     = m_tuser[0];
                got.overrun      = m_tuser[1];
                got.last_of_byte = m_tlast;
                if (predicted_words.size() == 0) begin
                    flag_mismatch("unexpected word, lanes", 16'h0, m_tdata[15:0]);
                end else begin
                    want = predicted_words.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got.lanes[k] !== want.lanes[k])
                            flag_mismatch($sformatf("pixel_lane%0d", k),
                                          16'(want.lanes[k]), 16'(got.lanes[k]));
                    if (got.count !== want.count)
                        flag_mismatch("byte_count", 16'(want.count), 16'(got.count));
                    if (got.row_done !== want.row_done)
                        flag_mismatch("row_done", 16'(want.row_done), 16'(got.row_done));
                    if (got.overrun !== want.overrun)
                        flag_mismatch("overrun", 16'(want.overrun), 16'(got.overrun));
                    if (got.last_of_byte !== want.last_of_byte)
                        flag_mismatch("last_of_item", 16'(want.last_of_byte),
                                      16'(got.last_of_byte));
                    if (want.row_done)
                        row_ends++;
                    if (want.overrun)
                        overrun_words++;
                end
                out_beats <= out_beats + 1;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [7:0] code, input logic row_begin,
                              input bit counts);
        stored_byte_t item;
        item.code = code;
        item.row_begin = row_begin;
        byte_feed.push_back(item);
        if (counts)
            counted++;
    endtask

    // One stored row: literal and run packets, then either a row end
    // (sometimes followed by bytes that must be ignored) or a dangling header.
    task automatic queue_rle_row(input int packets, input bit terminate, input bit restart);
        logic rb;
        int   cnt;
        rb = restart;
        for (int p = 0; p < packets; p++) begin
            if ($urandom_range(0, 1)) begin
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
                queue_byte(sirle_pkg::LITERAL_BIT | cnt[7:0], rb, 1'b1);
                rb = 1'b0;
                repeat (cnt) queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
                cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 127)
                                                  : $urandom_range(1, 12);
                queue_byte(cnt[7:0], rb, 1'b1);
                rb = 1'b0;
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
        if (terminate) begin
            queue_byte($urandom_range(0, 1) ? sirle_pkg::LITERAL_BIT : ROW_END_HDR, rb, 1'b1);
            repeat ($urandom_range(0, 2))
                queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
            queue_byte(8'($urandom_range(1, 255)) | 8'h01, rb, 1'b1);
        end
    endtask

    // Mostly well-formed rows, with some truncated rows and raw noise.
    task automatic queue_rle_phase(input int target, input bit first_restart);
        int start;
        int pick;
        bit restart;
        start = counted;
        restart = first_restart;
        while (counted - start < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 1'b1);
            end else begin
                queue_rle_row($urandom_range(1, 5), pick != 1, restart);
            end
            restart = 1'b1;
        end
    endtask

    task automatic queue_verbatim(input int n, input bit first_restart);
        queue_byte(8'($urandom_range(0, 255)), first_restart, 1'b1);
        repeat (n - 1)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b1);
    endtask

    // Wait until every byte is taken and every predicted word has arrived,
    // then let the block settle for bytes that yield nothing.
    task automatic settle();
        do @(negedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || predicted_words.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [sirle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sirle_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        gap_max = 4;

        // Reset settings: literals at both byte extremes, a short run, the
        // longest run, a run of exactly one word, and a row end.
        queue_byte(8'h83, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h5A, 1'b0, 1'b1);
        queue_byte(8'h05, 1'b0, 1'b1);
        queue_byte(8'hA5, 1'b0, 1'b1);
        queue_byte(8'h7F, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h81, 1'b0, 1'b1);
        queue_byte(8'h80, 1'b0, 1'b1);
        queue_byte(8'h04, 1'b0, 1'b1);
        queue_byte(8'h3C, 1'b0, 1'b1);
        queue_byte(ROW_END_HDR, 1'b0, 1'b1);
        // Bytes after the row end are ignored.
        queue_byte(8'h85, 1'b0, 1'b0);
        queue_byte(8'h12, 1'b0, 1'b0);
        // A zero count with the literal bit set also ends the row.
        queue_byte(sirle_pkg::LITERAL_BIT, 1'b1, 1'b1);
        // A row start in the middle of a literal packet.
        queue_byte(8'h82, 1'b1, 1'b1);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h01, 1'b1, 1'b1);
        queue_byte(8'h11, 1'b0, 1'b1);
        queue_byte(ROW_END_HDR, 1'b0, 1'b1);
        // Leave a literal packet open at pixel position two.
        queue_byte(8'h84, 1'b1, 1'b1);
        queue_byte(8'h10, 1'b0, 1'b1);
        queue_byte(8'h20, 1'b0, 1'b1);
        settle();

        // Row width lowered below the position, then partly and wholly
        // dropped pixels at the narrowest width.
        write_reg(sirle_pkg::CFG_ROW_WIDTH, 16'd1);
        queue_byte(8'h30, 1'b0, 1'b1);
        queue_byte(8'h40, 1'b0, 1'b1);
        queue_byte(8'h03, 1'b1, 1'b1);
        queue_byte(8'h44, 1'b0, 1'b1);
        queue_byte(8'h81, 1'b0, 1'b1);
        queue_byte(8'h55, 1'b0, 1'b1);
        queue_byte(ROW_END_HDR, 1'b0, 1'b1);
        settle();

        // Random rows at the widest row, sender never idle.
        write_reg(sirle_pkg::CFG_ROW_WIDTH, 16'hFFFF);
        gap_max = 0;
        queue_rle_phase(30, 1'b1);
        settle();

        // Random rows at a narrow width, so runs overflow often.
        write_reg(sirle_pkg::CFG_ROW_WIDTH, 16'($urandom_range(6, 40)));
        gap_max = 6;
        queue_rle_phase(30, 1'b1);
        settle();

        // Verbatim mode, first continuing the current row position.
        write_reg(sirle_pkg::CFG_STORAGE_MODE,
                  sirle_pkg::CFG_DATA_W'(sirle_pkg::MODE_VERBATIM));
        gap_max = 3;
        queue_verbatim(20, 1'b0);
        settle();
        write_reg(sirle_pkg::CFG_ROW_WIDTH, 16'd5);
        queue_verbatim(20, 1'b1);
        settle();

        // Back to run-length mode mid-row with a tiny width.
        write_reg(sirle_pkg::CFG_STORAGE_MODE,
                  sirle_pkg::CFG_DATA_W'(sirle_pkg::MODE_RLE));
        write_reg(sirle_pkg::CFG_ROW_WIDTH, 16'd2);
        gap_max = 2;
        queue_rle_phase(30, 1'b0);
        settle();

        $display("Fed %0d stored bytes through verbatim and run-length rows; %0d words out.",
                 in_beats, out_beats);
        $display("Checked %0d row ends and %0d overrun words; %0d field mismatches.",
                 row_ends, overrun_words, mismatches);
        if (mismatches == 0 && predicted_words.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
